// ----- rtl/aarm_pkg.sv -----
// ----------------------------------------------------------------------------
// aarm_pkg
// constants and helpers shared by the axis-angle rotation matrix pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 14;
  localparam int ZW           = 36;   // angle accumulator, q2.30 plus headroom
  localparam int XW           = 34;   // cordic x/y datapath
  localparam int PW           = 48;   // product width

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0: r = 36'sd843314856;
        1: r = 36'sd497837829;
        2: r = 36'sd263043836;
        3: r = 36'sd133525158;
        4: r = 36'sd67021686;
        5: r = 36'sd33543515;
        6: r = 36'sd16775850;
        7: r = 36'sd8388437;
        8: r = 36'sd4194282;
        9: r = 36'sd2097149;
        10: r = 36'sd1048575;
        11: r = 36'sd524287;
        12: r = 36'sd262143;
        13: r = 36'sd131071;
        14: r = 36'sd65535;
        15: r = 36'sd32767;
        16: r = 36'sd16383;
        17: r = 36'sd8191;
        18: r = 36'sd4095;
        19: r = 36'sd2047;
        20: r = 36'sd1023;
        21: r = 36'sd511;
        22: r = 36'sd255;
        default: r = 36'sd127;
      endcase
      return r;
    end
  endfunction

  // saturate to +-1.0 in q1.14
  function automatic logic [15:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] one;
    begin
      one = PW'(1) <<< FRAC_BITS;
      if (v > one) return one[15:0];
      if (v < -one) return 16'(-one);
      return v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/axis_angle_rotation_matrix.sv -----
// a request passes scale/wrap, fold, the cordic stages, round, products, times t, output register
// throughput: one request per cycle; every stage advances when the output register is free
// the cordic is unrolled, one micro-rotation per register stage
// reset: rst clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// rodrigues rotation matrix from angle (q3.12) and unit axis (q1.14)
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_rotation_matrix
  import aarm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // angle [15:0], axis_x [31:16], axis_y [47:32], axis_z [63:48]
  input  wire logic [63:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
  output logic [143:0]      m_axis_tdata
);

  localparam int NS = CORDIC_STEPS + 6;  // total stages incl. output

  // the whole pipe moves together; it stalls only when the output is held
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic [NS-2:0] vld;  // valid bits for the inner stages

  // axis travels beside the cordic
  logic signed [15:0] ux [CORDIC_STEPS+4];
  logic signed [15:0] uy [CORDIC_STEPS+4];
  logic signed [15:0] uz [CORDIC_STEPS+4];

  // stage 0: scale and wrap into [-pi, pi)
  logic signed [ZW-1:0] z0, z0w;
  logic signed [ZW-1:0] z1, z1f;
  logic                 flip [CORDIC_STEPS+2];
  logic signed [ZW-1:0] zc [CORDIC_STEPS+1];
  logic signed [XW-1:0] xc [CORDIC_STEPS+1];
  logic signed [XW-1:0] yc [CORDIC_STEPS+1];

  // a 16-bit angle times 2^18 lies within +-1.3 * 2pi, so one wrap either way
  always_comb begin
    z0 = ZW'($signed(s_axis_tdata[15:0])) <<< 18;
    if (z0 >= Q30_PI) z0w = z0 - Q30_TWO_PI;
    else if (z0 < -Q30_PI) z0w = z0 + Q30_TWO_PI;
    else z0w = z0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z1    <= z0w;
      ux[0] <= $signed(s_axis_tdata[31:16]);
      uy[0] <= $signed(s_axis_tdata[47:32]);
      uz[0] <= $signed(s_axis_tdata[63:48]);
    end
  end

  // stage 1: fold into [-pi/2, pi/2], flip negates sine and cosine
  logic fl1;
  always_comb begin
    z1f = z1;
    fl1 = 1'b0;
    if (z1 > Q30_HALF_PI) begin
      z1f = z1 - Q30_PI;
      fl1 = 1'b1;
    end else if (z1 < -Q30_HALF_PI) begin
      z1f = z1 + Q30_PI;
      fl1 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zc[0]   <= z1f;
      xc[0]   <= Q30_GAIN;
      yc[0]   <= '0;
      flip[0] <= fl1;
      ux[1]   <= ux[0];
      uy[1]   <= uy[0];
      uz[1]   <= uz[0];
    end
  end

  // cordic micro-rotations, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!zc[i][ZW-1]) begin
          xc[i+1] <= xc[i] - (yc[i] >>> i);
          yc[i+1] <= yc[i] + (xc[i] >>> i);
          zc[i+1] <= zc[i] - atan_q30(i);
        end else begin
          xc[i+1] <= xc[i] + (yc[i] >>> i);
          yc[i+1] <= yc[i] - (xc[i] >>> i);
          zc[i+1] <= zc[i] + atan_q30(i);
        end
        flip[i+1] <= flip[i];
        ux[i+2]   <= ux[i+1];
        uy[i+2]   <= uy[i+1];
        uz[i+2]   <= uz[i+1];
      end
    end
  end

  // flip and round cos/sin to q.14; t = 1 - cos
  localparam int RS = 30 - FRAC_BITS;
  logic signed [XW-1:0] xf, yf;
  logic signed [XW-1:0] cr, sr;
  always_comb begin
    xf = flip[CORDIC_STEPS] ? -xc[CORDIC_STEPS] : xc[CORDIC_STEPS];
    yf = flip[CORDIC_STEPS] ? -yc[CORDIC_STEPS] : yc[CORDIC_STEPS];
    cr = (xf + (XW'(1) <<< (RS - 1))) >>> RS;
    sr = (yf + (XW'(1) <<< (RS - 1))) >>> RS;
  end

  localparam int A = CORDIC_STEPS + 1;
  logic signed [19:0] cos_q, sin_q, t_q;
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_q <= cr[19:0];
      sin_q <= sr[19:0];
      t_q   <= 20'(20'sd1 <<< FRAC_BITS) - cr[19:0];
      ux[A+1] <= ux[A];
      uy[A+1] <= uy[A];
      uz[A+1] <= uz[A];
    end
  end

  // axis pair products and axis times sine
  logic signed [31:0] pp [6];
  logic signed [PW-1:0] sp [3];
  logic signed [19:0] t_d, c_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      pp[0] <= ux[A+1] * ux[A+1];
      pp[1] <= uy[A+1] * uy[A+1];
      pp[2] <= uz[A+1] * uz[A+1];
      pp[3] <= ux[A+1] * uy[A+1];
      pp[4] <= ux[A+1] * uz[A+1];
      pp[5] <= uy[A+1] * uz[A+1];
      sp[0] <= PW'(ux[A+1]) * PW'(sin_q);
      sp[1] <= PW'(uy[A+1]) * PW'(sin_q);
      sp[2] <= PW'(uz[A+1]) * PW'(sin_q);
      t_d   <= t_q;
      c_d   <= cos_q;
    end
  end

  // times t, round; round the sine terms
  logic signed [PW-1:0] pr [6];
  logic signed [PW-1:0] sr2 [3];
  logic signed [PW-1:0] c_e;
  for (genvar k = 0; k < 6; k++) begin : g_pt
    logic signed [PW-1:0] prod;
    assign prod = PW'(pp[k]) * PW'(t_d);
    always_ff @(posedge clk) begin
      if (adv) pr[k] <= (prod + (PW'(1) <<< (2*FRAC_BITS - 1))) >>> (2*FRAC_BITS);
    end
  end
  for (genvar k = 0; k < 3; k++) begin : g_sr
    always_ff @(posedge clk) begin
      if (adv) sr2[k] <= (sp[k] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) c_e <= PW'(c_d);
  end

  // sums and saturation into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata[15:0]    <= sat_out(c_e + pr[0]);
      m_axis_tdata[31:16]   <= sat_out(pr[3] - sr2[2]);
      m_axis_tdata[47:32]   <= sat_out(pr[4] + sr2[1]);
      m_axis_tdata[63:48]   <= sat_out(pr[3] + sr2[2]);
      m_axis_tdata[79:64]   <= sat_out(c_e + pr[1]);
      m_axis_tdata[95:80]   <= sat_out(pr[5] - sr2[0]);
      m_axis_tdata[111:96]  <= sat_out(pr[4] - sr2[1]);
      m_axis_tdata[127:112] <= sat_out(pr[5] + sr2[0]);
      m_axis_tdata[143:128] <= sat_out(c_e + pr[2]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      vld           <= {vld[NS-3:0], s_axis_tvalid};
      m_axis_tvalid <= vld[NS-2];
    end
  end

  // a held result keeps its data
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // a bubble taken while ready clears the first valid bit
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && !s_axis_tvalid |=> !vld[0])
    else $error("bubble lost in pipeline");

  // when stalled the pipe accepts nothing
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during stall");

endmodule

`default_nettype wire
